// ===== sv/rfc_pkg.sv =====
// Shared widths, register indexes and sequencer state codes for the rail fence block.
package rfc_pkg;

   localparam int DEFAULT_MAX_LEN = 64;

   localparam int BYTE_W     = 8;
   localparam int RAIL_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RAIL_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION  = 1'd1;

   localparam logic [RAIL_W-1:0] RAIL_RESET = 7'd2;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_WALK = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DUMP = 4'b1000
   } state_type;

endpackage

// ===== sv/rail_fence_cipher.sv =====
// Rail fence transposition block: message load, zig-zag position walk and result output.
//
// A message is loaded one word per cycle (start high while busy is low) until the word
// marked req_in_last; words beyond MAX_LEN are dropped and every result of that message
// then carries rsp_overflow. After the last word busy rises and a small sequencer walks
// the zig-zag rail order, one candidate position per cycle (two candidates per period
// step on each rail). The top and bottom rails waste one candidate per step. Encrypt
// emits each result in the cycle after its position is found, with gaps where candidates
// are skipped. Decrypt scatters the message into a result RAM during the walk and then
// reads it out linearly, one result per cycle. Results appear on rsp_* for exactly one
// cycle each, marked by rsp_strobe; the receiver cannot stall them. The next message may
// start as soon as busy falls. The user must write configuration only while idle; the
// block itself does not enforce it.
module rail_fence_cipher #(
   parameter int MAX_LEN = rfc_pkg::DEFAULT_MAX_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           start,
   output logic                           busy,
   input  logic [rfc_pkg::BYTE_W-1:0]     req_in_byte,
   input  logic                           req_in_last,
   // result words
   output logic                           rsp_strobe,
   output logic [rfc_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_out_last,
   output logic                           rsp_overflow,
   // configuration writes
   input  logic                           csr_write_en,
   input  logic [rfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import rfc_pkg::*;

   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   // walk index reaches past the message by up to two rails plus one period
   localparam int IW    = $clog2(MAX_LEN + 512) + 1;
   localparam int PER_W = RAIL_W + 1;

   // sequencer and counters
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [AW-1:0]        k_ff, k_in;
   logic [RAIL_W-1:0]    q_ff, q_in;
   logic [IW-1:0]        i_ff, i_in;
   logic                 sel_ff, sel_in;
   logic                 pass_ff, pass_in;
   logic [PER_W-1:0]     period_ff, period_in;
   logic [RAIL_W-1:0]    rm1_ff, rm1_in;

   // configuration
   logic [RAIL_W-1:0]    rail_ff, rail_in;
   logic                 dir_ff, dir_in;

   // result stage and scatter write stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_src_ff, rsp_src_in;
   logic                 wr_en_ff, wr_en_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;

   // memory ports
   logic                 msg_we;
   logic [AW-1:0]        msg_rd_addr;
   logic [BYTE_W-1:0]    msg_rd_data;
   logic [BYTE_W-1:0]    res_rd_data;

   // walk unit
   logic                 full;
   logic [CNT_W-1:0]     count_next;
   logic                 pos_valid;
   logic [AW-1:0]        pos;
   logic                 in_range;
   logic [IW-1:0]        b_pos;
   logic                 last_hit;

   assign full       = (count_ff == CNT_W'(MAX_LEN));
   assign count_next = full ? count_ff : count_ff + CNT_W'(1);
   assign last_hit   = ((CNT_W'(k_ff) + CNT_W'(1)) == len_ff);
   assign in_range   = (i_ff < (IW'(len_ff) + IW'(q_ff)));
   assign b_pos      = i_ff + IW'(q_ff);

   // one candidate position per cycle: i - q on the first half-step, i + q on the second; k in pass mode
   always_comb begin
      pos_valid = 1'b0;
      pos       = k_ff;
      if (pass_ff) begin
         pos_valid = 1'b1;
         pos       = k_ff;
      end else if (!sel_ff) begin
         pos_valid = in_range && (i_ff >= IW'(q_ff));
         pos       = AW'(i_ff - IW'(q_ff));
      end else begin
         // top rail meets itself, bottom rail meets the next period's i - q
         pos_valid = (b_pos < IW'(len_ff)) && (q_ff != '0) && (q_ff != rm1_ff);
         pos       = AW'(b_pos);
      end
   end

   assign msg_we      = start && !busy && !full;
   assign msg_rd_addr = (dir_ff == DIR_DECRYPT) ? k_ff : pos;

   // next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      sel_in       = sel_ff;
      pass_in      = pass_ff;
      period_in    = period_ff;
      rm1_in       = rm1_ff;
      rail_in      = rail_ff;
      dir_in       = dir_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_src_in   = rsp_src_ff;
      wr_en_in     = 1'b0;
      wr_addr_in   = wr_addr_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_RAIL_COUNT: rail_in = csr_write_data[RAIL_W-1:0];
            CSR_DIRECTION:  dir_in  = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               count_in = count_next;
               if (full) begin
                  ovf_in = 1'b1;
               end
               if (req_in_last) begin
                  state_in  = ST_WALK;
                  len_in    = count_next;
                  k_in      = '0;
                  q_in      = '0;
                  i_in      = '0;
                  sel_in    = 1'b0;
                  pass_in   = (rail_ff <= RAIL_W'(1));
                  period_in = {rail_ff, 1'b0} - PER_W'(2);
                  rm1_in    = rail_ff - RAIL_W'(1);
               end
            end
         end
         ST_WALK: begin
            // advance the walker
            if (!pass_ff) begin
               if (!sel_ff) begin
                  if (in_range) begin
                     sel_in = 1'b1;
                  end else begin
                     q_in = q_ff + RAIL_W'(1);
                     i_in = '0;
                  end
               end else begin
                  sel_in = 1'b0;
                  i_in   = i_ff + IW'(period_ff);
               end
            end
            if (pos_valid) begin
               k_in = k_ff + AW'(1);
               if (dir_ff == DIR_DECRYPT) begin
                  wr_en_in   = 1'b1;
                  wr_addr_in = pos;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = last_hit;
                  rsp_ovf_in   = ovf_ff;
                  rsp_src_in   = 1'b0;
               end
               if (last_hit) begin
                  if (dir_ff == DIR_DECRYPT) begin
                     state_in = ST_WAIT;
                  end else begin
                     state_in = ST_LOAD;
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
               end
            end
         end
         ST_WAIT: begin
            // last scatter write lands this cycle
            state_in = ST_DUMP;
            k_in     = '0;
         end
         ST_DUMP: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = last_hit;
            rsp_ovf_in   = ovf_ff;
            rsp_src_in   = 1'b1;
            k_in         = k_ff + AW'(1);
            if (last_hit) begin
               state_in = ST_LOAD;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rail_ff      <= RAIL_RESET;
         dir_ff       <= DIR_ENCRYPT;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rail_ff      <= rail_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_en_ff     <= wr_en_in;
      end
   end

   // walker and payload registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      k_ff        <= k_in;
      q_ff        <= q_in;
      i_ff        <= i_in;
      sel_ff      <= sel_in;
      pass_ff     <= pass_in;
      period_ff   <= period_in;
      rm1_ff      <= rm1_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_src_ff  <= rsp_src_in;
      wr_addr_ff  <= wr_addr_in;
   end

   // message store: written in arrival order
   rfc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_in_byte),
      .rd_addr (msg_rd_addr),
      .rd_data (msg_rd_data)
   );

   // result store: decrypt scatters into walk positions
   rfc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_res_ram (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (msg_rd_data),
      .rd_addr (k_ff),
      .rd_data (res_rd_data)
   );

   // outputs
   assign busy         = (state_ff != ST_LOAD);
   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_out_byte = rsp_src_ff ? res_rd_data : msg_rd_data;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// ===== sv/rfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
